### hw/rtl/hrhp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP request head parser package
// Types, codes and per-byte update functions shared by the parser.
// ----------------------------------------------------------------------------
package hrhp_pkg;

  localparam int MAX_REQUEST_BYTES = 65536;
  localparam int POS_W             = 16;
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_REQUEST_BYTES - 1);

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef enum logic [6:0] {
    PH_SKIP    = 7'b0000001,
    PH_METHOD  = 7'b0000010,
    PH_TARGET  = 7'b0000100,
    PH_VERSION = 7'b0001000,
    PH_HEADER  = 7'b0010000,
    PH_BODY    = 7'b0100000,
    PH_ABORT   = 7'b1000000
  } phase_t;

  typedef enum logic [1:0] {
    EV_START = 2'd0,
    EV_FIELD = 2'd1,
    EV_BODY  = 2'd2,
    EV_ERROR = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    M_GET     = 3'd0,
    M_HEAD    = 3'd1,
    M_POST    = 3'd2,
    M_PUT     = 3'd3,
    M_DELETE  = 3'd4,
    M_CONNECT = 3'd5,
    M_OPTIONS = 3'd6,
    M_TRACE   = 3'd7
  } method_t;

  typedef enum logic [3:0] {
    ERR_NONE           = 4'd0,
    ERR_TRUNCATED      = 4'd1,
    ERR_EMPTY_METHOD   = 4'd2,
    ERR_EMPTY_TARGET   = 4'd3,
    ERR_EMPTY_VERSION  = 4'd4,
    ERR_UNKNOWN_METHOD = 4'd5,
    ERR_NO_COLON       = 4'd6,
    ERR_EMPTY_KEY      = 4'd7,
    ERR_TOO_LONG       = 4'd8
  } err_t;

  typedef struct packed {
    phase_t           phase;
    logic             cr;      // CR seen, waiting for LF
    logic [POS_W-1:0] pos;
    logic [7:0]       cand;    // method candidates
    logic [2:0]       mlen;    // method length so far, saturating
    logic [POS_W-1:0] tok;
    logic [POS_W-1:0] fse;     // first span end
    logic [POS_W-1:0] vfn;     // value first non-blank
    logic [POS_W-1:0] vln;     // value last non-blank, exclusive
    logic             colon;
    err_t             lerr;
  } st_t;

  typedef struct packed {
    kind_t            kind;
    method_t          method;
    logic [POS_W-1:0] a0;
    logic [POS_W-1:0] a1;
    logic [POS_W-1:0] b0;
    logic [POS_W-1:0] b1;
    err_t             err;
  } res_t;

  typedef struct packed {
    st_t  s;
    res_t r;
    logic has;
  } le_t;

  function automatic st_t st_reset();
    st_t s;
    s       = '0;
    s.phase = PH_SKIP;
    s.cand  = 8'hFF;
    s.lerr  = ERR_NONE;
    return s;
  endfunction

  function automatic err_t latch(err_t cur, err_t code);
    return (cur == ERR_NONE) ? code : cur;
  endfunction

  function automatic logic [2:0] method_len(method_t m);
    logic [2:0] l;
    unique case (m)
      M_GET:     l = 3'd3;
      M_HEAD:    l = 3'd4;
      M_POST:    l = 3'd4;
      M_PUT:     l = 3'd3;
      M_DELETE:  l = 3'd6;
      M_CONNECT: l = 3'd7;
      M_OPTIONS: l = 3'd7;
      M_TRACE:   l = 3'd5;
    endcase
    return l;
  endfunction

  // Character k of a method name, zero past its end
  function automatic logic [7:0] method_char(method_t m, logic [2:0] k);
    logic [63:0] w;
    unique case (m)
      M_GET:     w = {"GET", 40'd0};
      M_HEAD:    w = {"HEAD", 32'd0};
      M_POST:    w = {"POST", 32'd0};
      M_PUT:     w = {"PUT", 40'd0};
      M_DELETE:  w = {"DELETE", 16'd0};
      M_CONNECT: w = {"CONNECT", 8'd0};
      M_OPTIONS: w = {"OPTIONS", 8'd0};
      M_TRACE:   w = {"TRACE", 24'd0};
    endcase
    return w[{~k, 3'b000} +: 8];
  endfunction

  // Apply one non-terminating byte b at offset p
  function automatic st_t ordinary(st_t s, logic [7:0] b, logic [POS_W-1:0] p);
    st_t n;
    n = s;
    if (n.phase == PH_SKIP) begin
      n.phase = PH_METHOD;
      n.tok   = p;
    end
    unique case (n.phase)
      PH_METHOD: begin
        if (b == CH_SP) begin
          if (p == n.tok) n.lerr = latch(n.lerr, ERR_EMPTY_METHOD);
          n.tok   = p + POS_W'(1);
          n.phase = PH_TARGET;
        end else begin
          for (int i = 0; i < 8; i++) begin
            if (method_len(method_t'(i)) <= n.mlen ||
                method_char(method_t'(i), n.mlen) != b) begin
              n.cand[i] = 1'b0;
            end
          end
          if (n.mlen != 3'd7) n.mlen = n.mlen + 3'd1;
        end
      end
      PH_TARGET: begin
        if (b == CH_SP) begin
          if (p == n.tok) n.lerr = latch(n.lerr, ERR_EMPTY_TARGET);
          n.fse   = p;
          n.vfn   = p + POS_W'(1);
          n.phase = PH_VERSION;
        end
      end
      PH_HEADER: begin
        if (!n.colon) begin
          if (b == CH_COLON) begin
            n.colon = 1'b1;
            n.fse   = p;
            n.vfn   = p + POS_W'(1);
            n.vln   = p + POS_W'(1);
          end
        end else if (b == CH_SP || b == CH_TAB) begin
          if (n.vfn == n.vln) begin
            n.vfn = p + POS_W'(1);
            n.vln = p + POS_W'(1);
          end
        end else begin
          if (n.vfn == n.vln) n.vfn = p;
          n.vln = p + POS_W'(1);
        end
      end
      default: ;
    endcase
    return n;
  endfunction

  // Complete a line whose CR sits at offset e
  function automatic le_t line_end(st_t s, logic [POS_W-1:0] e);
    le_t     o;
    method_t m;
    logic    found;
    o       = '0;
    o.s     = s;
    o.has   = 1'b0;
    m       = M_GET;
    found   = 1'b0;
    unique case (s.phase)
      PH_SKIP:    o.s.tok = e + POS_W'(2);
      PH_METHOD:  o.s.lerr = latch(o.s.lerr, ERR_EMPTY_TARGET);
      PH_TARGET:  o.s.lerr = latch(o.s.lerr, ERR_EMPTY_VERSION);
      PH_VERSION: begin
        if (e == s.vfn) o.s.lerr = latch(o.s.lerr, ERR_EMPTY_VERSION);
      end
      PH_HEADER: begin
        if (e == s.tok) begin
          o.s.phase = PH_BODY;
          o.s.tok   = e + POS_W'(2);
        end else begin
          if (!s.colon) o.s.lerr = latch(o.s.lerr, ERR_NO_COLON);
          else if (s.fse == s.tok) o.s.lerr = latch(o.s.lerr, ERR_EMPTY_KEY);
          else if (s.fse + POS_W'(1) == e) o.s.lerr = latch(o.s.lerr, ERR_NO_COLON);
          o.has = 1'b1;
          if (o.s.lerr != ERR_NONE) begin
            o.r.kind = EV_ERROR;
            o.r.err  = o.s.lerr;
          end else begin
            o.r.kind  = EV_FIELD;
            o.r.a0    = s.tok;
            o.r.a1    = s.fse;
            o.r.b0    = s.vfn;
            o.r.b1    = s.vln;
            o.s.tok   = e + POS_W'(2);
            o.s.colon = 1'b0;
          end
        end
      end
      default: ;
    endcase
    if (s.phase == PH_METHOD || s.phase == PH_TARGET || s.phase == PH_VERSION) begin
      // lowest matching method code wins
      for (int i = 7; i >= 0; i--) begin
        if (s.cand[i] && method_len(method_t'(i)) == s.mlen) begin
          found = 1'b1;
          m     = method_t'(i);
        end
      end
      if (!found) o.s.lerr = latch(o.s.lerr, ERR_UNKNOWN_METHOD);
      o.has = 1'b1;
      if (o.s.lerr != ERR_NONE) begin
        o.r.kind = EV_ERROR;
        o.r.err  = o.s.lerr;
      end else begin
        o.r.kind   = EV_START;
        o.r.method = m;
        o.r.a0     = s.tok;
        o.r.a1     = s.fse;
        o.r.b0     = s.vfn;
        o.r.b1     = e;
        o.s.phase  = PH_HEADER;
        o.s.tok    = e + POS_W'(2);
        o.s.colon  = 1'b0;
      end
    end
    return o;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/http_request_head_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP request head parser
// Parses a request byte stream into start-line, header, body and error words.
// ----------------------------------------------------------------------------
// Path: a taken byte waits in the input register, its result word in the result
//   register. Throughput: one byte per cycle unless a word stalls in a full
//   result register; the per-byte state update is a single pass of combinational
//   logic between the input register and the parse state.
// Reset: synchronous, active high; clears both registers' valid flags and
//   returns the parse state to skipping leading empty lines.
// ----------------------------------------------------------------------------
module http_request_head_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  wire logic        s_axis_tlast,  // last_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [2:0] method_code, [18:3] span_a_start, [34:19] span_a_end,
  // [50:35] span_b_start, [66:51] span_b_end, [70:67] error_code, [71] zero
  output logic [71:0]      m_axis_tdata,
  output logic [1:0]       m_axis_tuser   // [1:0] event_kind
);

  // Input register: holds one byte until the parse state can take it
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // Parse state and result register
  hrhp_pkg::st_t  parse_st;
  hrhp_pkg::st_t  parse_st_next;
  hrhp_pkg::res_t res;
  hrhp_pkg::res_t res_next;
  logic           res_valid;
  logic           has_res;
  hrhp_pkg::le_t  le;
  logic           advance;
  logic           done;

  // A byte advances when it makes no word, or the result register is free
  assign advance       = in_valid && (!has_res || !res_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Line completion is worked out from the current state; used only on CR LF
  assign le = hrhp_pkg::line_end(parse_st, parse_st.pos - hrhp_pkg::POS_W'(1));

  always_comb begin
    parse_st_next = parse_st;
    res_next      = '0;
    has_res       = 1'b0;
    done          = 1'b0;
    if (parse_st.phase == hrhp_pkg::PH_ABORT) begin
      // drop bytes until the end of the request
      if (in_last) parse_st_next = hrhp_pkg::st_reset();
    end else if (parse_st.pos >= hrhp_pkg::POS_LIMIT) begin
      has_res       = 1'b1;
      res_next.kind = hrhp_pkg::EV_ERROR;
      res_next.err  = hrhp_pkg::ERR_TOO_LONG;
      if (in_last) parse_st_next = hrhp_pkg::st_reset();
      else parse_st_next.phase = hrhp_pkg::PH_ABORT;
    end else begin
      if (parse_st.cr) begin
        if (in_byte == hrhp_pkg::CH_LF) begin
          parse_st_next = le.s;
          res_next      = le.r;
          has_res       = le.has;
          done          = 1'b1;
        end else begin
          // a lone CR is an ordinary byte at the previous offset
          parse_st_next = hrhp_pkg::ordinary(parse_st, hrhp_pkg::CH_CR,
                                             parse_st.pos - hrhp_pkg::POS_W'(1));
        end
        parse_st_next.cr = 1'b0;
      end
      if (!done) begin
        if (in_byte == hrhp_pkg::CH_CR && !in_last) parse_st_next.cr = 1'b1;
        else parse_st_next = hrhp_pkg::ordinary(parse_st_next, in_byte, parse_st.pos);
      end
      parse_st_next.pos = parse_st.pos + hrhp_pkg::POS_W'(1);

      if (has_res && res_next.kind == hrhp_pkg::EV_ERROR) begin
        if (in_last) parse_st_next = hrhp_pkg::st_reset();
        else parse_st_next.phase = hrhp_pkg::PH_ABORT;
      end else if (in_last) begin
        // end of buffer: body span if the head is complete, else truncated
        has_res  = 1'b1;
        res_next = '0;
        if (parse_st_next.phase == hrhp_pkg::PH_BODY) begin
          res_next.kind = hrhp_pkg::EV_BODY;
          res_next.a0   = parse_st_next.tok;
          res_next.a1   = parse_st.pos + hrhp_pkg::POS_W'(1);
        end else begin
          res_next.kind = hrhp_pkg::EV_ERROR;
          res_next.err  = hrhp_pkg::ERR_TRUNCATED;
        end
        parse_st_next = hrhp_pkg::st_reset();
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_st <= hrhp_pkg::st_reset();
    end else if (advance) begin
      parse_st <= parse_st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && has_res) begin
      res_valid <= 1'b1;
    end else if (m_axis_tready) begin
      res_valid <= 1'b0;
    end
    if (advance && has_res) begin
      res <= res_next;
    end
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tuser  = res.kind;
  assign m_axis_tdata  = {1'b0, res.err, res.b1, res.b0, res.a1, res.a0, res.method};

endmodule
`default_nettype wire
